// ===== src/bba_pkg.sv =====
`default_nettype none

package bba_pkg;

    localparam int REQ_SIZE_W = 11;
    localparam int ADDR_W     = 10;
    localparam int ORD_W      = 5;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TOO_BIG  = 2'd1;
    localparam logic [1:0] ST_NO_MEM   = 2'd2;
    localparam logic [1:0] ST_BAD_FREE = 2'd3;

    typedef struct packed {
        logic                  command;
        logic [REQ_SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0]     free_address;
    } bba_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] block_address;
        logic [1:0]        status;
    } bba_rsp_t;

endpackage

`default_nettype wire

// ===== src/bba_ram.sv =====
`default_nettype none

module bba_ram #(
    parameter int W     = 1,
    parameter int AW    = 1,
    parameter int DEPTH = 2
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/buddy_block_allocator_unit.sv =====
`default_nettype none

// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready  | in_data  (command, request_size, free_address)
// out     | output    | out_valid / out_ready| out_data (block_address, status)
//
// One request at a time; in_ready is high only in the idle state. An allocate goes through the
// root read, descent and splits, walk-up and result; a free goes through the order lookup, the
// merges, the set of the merged block and the walk-up to the root, then the result. Rejected
// requests skip to the result state.
// After reset a clearing pass over both memories runs before in_ready rises.
// The result state stalls only while the previous result is still unaccepted at the output.

module buddy_block_allocator_unit #(
    parameter int POOL_UNITS = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bba_pkg::bba_req_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output bba_pkg::bba_rsp_t out_data
);

    import bba_pkg::*;

    localparam int ORDER_LEVELS = $clog2(POOL_UNITS) + 1;
    localparam int LW           = ORDER_LEVELS;      // heap index and order-mask width
    localparam int OW           = ORDER_LEVELS - 1;  // unit offset width
    localparam logic [ORD_W-1:0] TOP_O = ORD_W'(ORDER_LEVELS - 1);

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_A_ROOT = 4'd2;
    localparam logic [3:0] S_A_DN   = 4'd3;
    localparam logic [3:0] S_A_SPL  = 4'd4;
    localparam logic [3:0] S_F_ORD  = 4'd5;
    localparam logic [3:0] S_F_MRG  = 4'd6;
    localparam logic [3:0] S_F_UP   = 4'd7;
    localparam logic [3:0] S_F_SET  = 4'd8;
    localparam logic [3:0] S_W_RD   = 4'd9;
    localparam logic [3:0] S_W_WR   = 4'd10;
    localparam logic [3:0] S_RES    = 4'd11;

    logic [3:0]       state_reg, state_next;
    logic [LW-1:0]    cnt_reg, cnt_next;
    logic [LW-1:0]    h_reg, h_next;
    logic [LW-1:0]    mc_reg, mc_next;
    logic [ORD_W-1:0] o_reg, o_next;
    logic [ORD_W-1:0] k_reg, k_next;
    logic [ORD_W-1:0] ord_reg, ord_next;
    logic [OW-1:0]    off_reg, off_next;
    bba_rsp_t         res_reg, res_next;
    bba_rsp_t         out_data_reg;
    logic             out_valid_reg;
    logic             out_load;

    // node mask memory: bit j of entry h set when a free order-j block lies under node h
    logic          mask_we;
    logic [LW-1:0] mask_waddr, mask_wdata, mask_raddr, mask_rdata;

    // recorded order + 1 per unit offset
    logic             om_we;
    logic [OW-1:0]    om_waddr, om_raddr;
    logic [ORD_W-1:0] om_wdata, om_rdata;

    bba_ram #(.W(LW), .AW(LW), .DEPTH(2 ** LW)) u_mask_ram (
        .clk   (clk),
        .we    (mask_we),
        .waddr (mask_waddr),
        .wdata (mask_wdata),
        .raddr (mask_raddr),
        .rdata (mask_rdata)
    );

    bba_ram #(.W(ORD_W), .AW(OW), .DEPTH(POOL_UNITS)) u_order_ram (
        .clk   (clk),
        .we    (om_we),
        .waddr (om_waddr),
        .wdata (om_wdata),
        .raddr (om_raddr),
        .rdata (om_rdata)
    );

    // request decode
    logic [REQ_SIZE_W-1:0] size_m;
    logic [ORD_W-1:0]      req_k;
    logic                  req_big;
    logic                  addr_ok;
    logic [OW+ADDR_W-1:0]  addr_wide;
    logic [OW-1:0]         in_off;
    logic [OW+ADDR_W-1:0]  off_wide;

    always_comb
    begin
        size_m = (in_data.request_size == '0) ? '0 : in_data.request_size - 1'b1;
        req_k  = '0;
        for (int i = 0; i < REQ_SIZE_W; i++)
        begin
            if (size_m[i])
            begin
                req_k = ORD_W'(i + 1);
            end
        end
    end

    assign req_big   = req_k > TOP_O;
    assign addr_ok   = 32'(in_data.free_address) < POOL_UNITS;
    assign addr_wide = {OW'(0), in_data.free_address};
    assign in_off    = addr_wide[OW-1:0];
    assign off_wide  = {ADDR_W'(0), off_reg};

    // smallest free order at or above k, from the root mask
    logic [LW-1:0]    cand;
    logic [ORD_W-1:0] ord_pick;

    always_comb
    begin
        ord_pick = '0;
        for (int i = 0; i < LW; i++)
        begin
            cand[i] = mask_rdata[i] && (ORD_W'(i) >= k_reg);
        end
        for (int i = LW - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                ord_pick = ORD_W'(i);
            end
        end
    end

    // free decode from the recorded order
    logic [ORD_W-1:0] fo_raw, fo;
    logic [OW-1:0]    f_off;
    logic [LW-1:0]    f_h;
    logic [LW-1:0]    bit_o;
    logic             rd_hit;

    assign fo_raw = om_rdata - 1'b1;
    assign fo     = (fo_raw > TOP_O) ? TOP_O : fo_raw;
    assign f_off  = off_reg & ((~OW'(0)) << fo);
    assign f_h    = (LW'(1) << (TOP_O - fo)) | (LW'(f_off) >> fo);
    assign bit_o  = LW'(1) << o_reg;
    assign rd_hit = |(mask_rdata & bit_o);

    logic [ORD_W-1:0] o_dec;
    logic [LW-1:0]    h_dn;
    logic [LW-1:0]    h_up;
    logic [LW-1:0]    pm;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        h_next     = h_reg;
        mc_next    = mc_reg;
        o_next     = o_reg;
        k_next     = k_reg;
        ord_next   = ord_reg;
        off_next   = off_reg;
        res_next   = res_reg;
        in_ready   = 1'b0;
        mask_we    = 1'b0;
        mask_waddr = h_reg;
        mask_wdata = '0;
        mask_raddr = h_reg ^ LW'(1);
        om_we      = 1'b0;
        om_waddr   = off_reg;
        om_wdata   = '0;
        om_raddr   = in_off;
        o_dec      = o_reg - 1'b1;
        h_dn       = '0;
        h_up       = h_reg >> 1;
        pm         = mc_reg | mask_rdata;

        case (state_reg)
            S_CLR:
            begin
                mask_we    = 1'b1;
                mask_waddr = cnt_reg;
                mask_wdata = (cnt_reg == LW'(1)) ? (LW'(1) << TOP_O) : '0;
                om_we      = ~cnt_reg[LW-1];
                om_waddr   = cnt_reg[OW-1:0];
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready   = 1'b1;
                mask_raddr = LW'(1);
                if (in_valid)
                begin
                    res_next.block_address = '0;
                    res_next.status        = ST_OK;
                    if (in_data.command == CMD_ALLOC)
                    begin
                        k_next   = req_k;
                        off_next = '0;
                        if (req_big)
                        begin
                            res_next.status = ST_TOO_BIG;
                            state_next      = S_RES;
                        end
                        else
                        begin
                            state_next = S_A_ROOT;
                        end
                    end
                    else
                    begin
                        off_next = in_off;
                        if (!addr_ok)
                        begin
                            res_next.status = ST_BAD_FREE;
                            state_next      = S_RES;
                        end
                        else
                        begin
                            state_next = S_F_ORD;
                        end
                    end
                end
            end
            S_A_ROOT:
            begin
                if (cand == '0)
                begin
                    res_next.status = ST_NO_MEM;
                    state_next      = S_RES;
                end
                else
                begin
                    ord_next = ord_pick;
                    h_next   = LW'(1);
                    o_next   = TOP_O;
                    if (ord_pick == TOP_O)
                    begin
                        state_next = S_A_SPL;
                    end
                    else
                    begin
                        mask_raddr = LW'(2);
                        state_next = S_A_DN;
                    end
                end
            end
            S_A_DN:
            begin
                // rdata is the left child; go left if it holds a free block of the order
                if (|(mask_rdata & (LW'(1) << ord_reg)))
                begin
                    h_dn = LW'({h_reg, 1'b0});
                end
                else
                begin
                    h_dn     = LW'({h_reg, 1'b1});
                    off_next = off_reg + (OW'(1) << o_dec);
                end
                h_next = h_dn;
                o_next = o_dec;
                if (o_dec == ord_reg)
                begin
                    state_next = S_A_SPL;
                end
                else
                begin
                    mask_raddr = LW'({h_dn, 1'b0});
                end
            end
            S_A_SPL:
            begin
                mask_we = 1'b1;
                if (o_reg == k_reg)
                begin
                    mask_waddr             = h_reg;
                    mask_wdata             = '0;
                    om_we                  = 1'b1;
                    om_waddr               = off_reg;
                    om_wdata               = k_reg + 1'b1;
                    res_next.block_address = off_wide[ADDR_W-1:0];
                    mc_next                = '0;
                    state_next             = S_W_RD;
                end
                else
                begin
                    // upper half becomes free, keep splitting the lower half
                    mask_waddr = LW'({h_reg, 1'b1});
                    mask_wdata = LW'(1) << o_dec;
                    h_next     = LW'({h_reg, 1'b0});
                    o_next     = o_dec;
                end
            end
            S_F_ORD:
            begin
                if (om_rdata == '0)
                begin
                    res_next.status = ST_BAD_FREE;
                    state_next      = S_RES;
                end
                else
                begin
                    om_we    = 1'b1;
                    om_waddr = off_reg;
                    om_wdata = '0;
                    o_next   = fo;
                    h_next   = f_h;
                    if (fo == TOP_O)
                    begin
                        state_next = S_F_SET;
                    end
                    else
                    begin
                        mask_raddr = f_h ^ LW'(1);
                        state_next = S_F_MRG;
                    end
                end
            end
            S_F_MRG:
            begin
                if (rd_hit)
                begin
                    mask_we    = 1'b1;
                    mask_waddr = h_reg ^ LW'(1);
                    mask_wdata = '0;
                    state_next = S_F_UP;
                end
                else
                begin
                    state_next = S_F_SET;
                end
            end
            S_F_UP:
            begin
                mask_we    = 1'b1;
                mask_waddr = h_reg;
                mask_wdata = '0;
                h_next     = h_up;
                o_next     = o_reg + 1'b1;
                if (o_reg + 1'b1 == TOP_O)
                begin
                    state_next = S_F_SET;
                end
                else
                begin
                    mask_raddr = h_up ^ LW'(1);
                    state_next = S_F_MRG;
                end
            end
            S_F_SET:
            begin
                mask_we    = 1'b1;
                mask_waddr = h_reg;
                mask_wdata = bit_o;
                mc_next    = bit_o;
                state_next = S_W_RD;
            end
            S_W_RD:
            begin
                if (h_reg == LW'(1))
                begin
                    state_next = S_RES;
                end
                else
                begin
                    mask_raddr = h_reg ^ LW'(1);
                    state_next = S_W_WR;
                end
            end
            S_W_WR:
            begin
                // ancestors are split, so a parent's mask is the union of its children
                mask_we    = 1'b1;
                mask_waddr = h_up;
                mask_wdata = pm;
                mc_next    = pm;
                h_next     = h_up;
                if (h_up == LW'(1))
                begin
                    state_next = S_RES;
                end
                else
                begin
                    mask_raddr = h_up ^ LW'(1);
                end
            end
            S_RES:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_load = (state_reg == S_RES) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg   <= h_next;
        mc_reg  <= mc_next;
        o_reg   <= o_next;
        k_reg   <= k_next;
        ord_reg <= ord_next;
        off_reg <= off_next;
        res_reg <= res_next;
        if (out_load)
        begin
            out_data_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // entry 0 of the mask memory is never a tree node once the clearing pass is done
    a_no_node_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_CLR) && mask_we |-> mask_waddr != '0)
        else $error("mask write to unused entry");

    a_descend_above_target: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_A_DN |-> o_reg > ord_reg)
        else $error("descent passed target order");

    a_walk_below_root: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_W_WR |-> h_reg != LW'(1))
        else $error("walk-up past root");

endmodule

`default_nettype wire
